>>> rtl/assert_macros.svh
// assertion macros for the decoder top rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/bmpdec_pkg.sv
// shared constants for the bmp stream pixel decoder
package bmpdec_pkg;

  // result kinds
  localparam logic [2:0] KIND_PIXEL   = 3'd0;
  localparam logic [2:0] KIND_SKIP    = 3'd1;
  localparam logic [2:0] KIND_HDR_OK  = 3'd2;
  localparam logic [2:0] KIND_BAD_SIG = 3'd3;
  localparam logic [2:0] KIND_UNSUPP  = 3'd4;

  // parse phases
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_GAP    = 2'd1;
  localparam logic [1:0] PH_PIXELS = 2'd2;
  localparam logic [1:0] PH_IDLE   = 2'd3;

  // file format constants
  localparam logic [15:0] BMP_SIGNATURE   = 16'h4d42;
  localparam logic [15:0] HDR_LEN         = 16'd54;
  localparam logic [15:0] HDR_LAST        = 16'd53;
  localparam logic [31:0] MAX_DIM         = 32'd1024;
  localparam logic [31:0] MAX_DATA_OFFSET = 32'd65535;
  localparam logic [15:0] BPP_8           = 16'd8;
  localparam logic [15:0] BPP_24          = 16'd24;

  // palette geometry
  localparam int          PAL_DEPTH = 256;
  localparam int          PAL_IDX_W = 8;
  localparam logic [8:0]  PAL_FULL  = 9'd256;

endpackage

>>> rtl/bmp_stream_pixel_decoder_top.sv
// bmp stream pixel decoder: header parse, palette capture and pixel decode
// pipeline: two register stages, stage one then the result register, which holds while result_stall is high
// throughput: one byte per cycle while byte_stall is low; the palette memory read is the only registered lookup
// bytes that give no result only pass through the state update
// reset (rst, synchronous) returns the parser to the header phase at byte 0;
// palette contents are not cleared and hold what earlier files wrote
module bmp_stream_pixel_decoder_top
  import bmpdec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        file_start,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  kind,
  output logic [9:0]  x_pos,
  output logic [9:0]  y_pos,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [10:0] img_width,
  output logic [10:0] img_height,
  output logic        last_pixel
);

`include "assert_macros.svh"

  // parse state
  logic [15:0] byte_position, byte_position_next;
  logic [1:0]  phase, phase_next;
  logic [15:0] signature_word, signature_word_next;
  logic [31:0] data_offset, data_offset_next;
  logic [31:0] width_field, width_field_next;
  logic [31:0] height_field, height_field_next;
  logic [15:0] bits_per_pixel, bits_per_pixel_next;
  logic [31:0] pal_count, pal_count_next;
  logic [8:0]  palette_limit, palette_limit_next;
  logic [10:0] file_row, file_row_next;
  logic [11:0] row_byte_count, row_byte_count_next;
  logic [15:0] held_bytes, held_bytes_next;
  logic [11:0] row_bytes, row_bytes_next;
  logic [11:0] data_limit, data_limit_next;
  logic        mode8, mode8_next;
  logic [1:0]  row_lane, row_lane_next;
  logic [9:0]  pix_x, pix_x_next;

  // stage one registers
  logic        s1_v;
  logic [2:0]  s1_kind;
  logic [9:0]  s1_x, s1_y;
  logic [7:0]  s1_r, s1_g, s1_b;
  logic [10:0] s1_w, s1_h;
  logic        s1_last, s1_pal;

  // stage one next values
  logic        fire;
  logic [2:0]  r_kind;
  logic [9:0]  r_x, r_y;
  logic [7:0]  r_r, r_g, r_b;
  logic [10:0] r_w, r_h;
  logic        r_last, r_pal;

  // palette memory, one array per color byte
  logic [7:0]  pal_red   [PAL_DEPTH];
  logic [7:0]  pal_green [PAL_DEPTH];
  logic [7:0]  pal_blue  [PAL_DEPTH];
  logic [7:0]  red_q, green_q, blue_q;
  logic        we_red, we_green, we_blue;
  logic [PAL_IDX_W-1:0] wr_idx;

  // working values
  logic        accept, load;
  logic [15:0] cur_pos;
  logic [1:0]  cur_phase;
  logic [15:0] rel;
  logic [31:0] pos_inc;
  logic [10:0] w11, h11, w_m1, h_m1;
  logic [11:0] rc_inc;
  logic [10:0] row_inc;
  logic        hdr_bad;

  assign accept     = byte_valid && !byte_stall;
  assign load       = s1_v && (!result_valid || !result_stall);
  assign byte_stall = s1_v && result_valid && result_stall;

  assign cur_pos   = file_start ? 16'd0 : byte_position;
  assign cur_phase = file_start ? PH_HEADER : phase;
  assign rel       = cur_pos - HDR_LEN;
  assign pos_inc   = {16'd0, cur_pos} + 32'd1;
  assign w11       = width_field[10:0];
  assign h11       = height_field[10:0];
  assign w_m1      = w11 - 11'd1;
  assign h_m1      = h11 - 11'd1;
  assign rc_inc    = row_byte_count + 12'd1;
  assign row_inc   = file_row + 11'd1;
  assign wr_idx    = rel[PAL_IDX_W+1:2];

  // per-byte parse and result formation
  always_comb begin
    byte_position_next  = cur_pos;
    phase_next          = cur_phase;
    signature_word_next = file_start ? 16'd0 : signature_word;
    data_offset_next    = file_start ? 32'd0 : data_offset;
    width_field_next    = file_start ? 32'd0 : width_field;
    height_field_next   = file_start ? 32'd0 : height_field;
    bits_per_pixel_next = file_start ? 16'd0 : bits_per_pixel;
    pal_count_next      = file_start ? 32'd0 : pal_count;
    palette_limit_next  = file_start ? PAL_FULL : palette_limit;
    file_row_next       = file_start ? 11'd0 : file_row;
    row_byte_count_next = file_start ? 12'd0 : row_byte_count;
    held_bytes_next     = file_start ? 16'd0 : held_bytes;
    row_bytes_next      = row_bytes;
    data_limit_next     = data_limit;
    mode8_next          = mode8;
    row_lane_next       = file_start ? 2'd0 : row_lane;
    pix_x_next          = file_start ? 10'd0 : pix_x;
    fire     = 1'b0;
    r_kind   = KIND_PIXEL;
    r_x      = 10'd0;
    r_y      = 10'd0;
    r_r      = 8'd0;
    r_g      = 8'd0;
    r_b      = 8'd0;
    r_w      = 11'd0;
    r_h      = 11'd0;
    r_last   = 1'b0;
    r_pal    = 1'b0;
    we_red   = 1'b0;
    we_green = 1'b0;
    we_blue  = 1'b0;
    hdr_bad  = 1'b0;

    case (cur_phase)
      PH_HEADER: begin
        // little-endian field capture
        case (cur_pos)
          16'd0:  signature_word_next[7:0]   = data_byte;
          16'd1:  signature_word_next[15:8]  = data_byte;
          16'd10: data_offset_next[7:0]      = data_byte;
          16'd11: data_offset_next[15:8]     = data_byte;
          16'd12: data_offset_next[23:16]    = data_byte;
          16'd13: data_offset_next[31:24]    = data_byte;
          16'd18: width_field_next[7:0]      = data_byte;
          16'd19: width_field_next[15:8]     = data_byte;
          16'd20: width_field_next[23:16]    = data_byte;
          16'd21: width_field_next[31:24]    = data_byte;
          16'd22: height_field_next[7:0]     = data_byte;
          16'd23: height_field_next[15:8]    = data_byte;
          16'd24: height_field_next[23:16]   = data_byte;
          16'd25: height_field_next[31:24]   = data_byte;
          16'd28: bits_per_pixel_next[7:0]   = data_byte;
          16'd29: bits_per_pixel_next[15:8]  = data_byte;
          16'd46: pal_count_next[7:0]        = data_byte;
          16'd47: pal_count_next[15:8]       = data_byte;
          16'd48: pal_count_next[23:16]      = data_byte;
          16'd49: pal_count_next[31:24]      = data_byte;
          default: ;
        endcase
        byte_position_next = pos_inc[15:0];
        // header verdict on the last header byte
        if (cur_pos == HDR_LAST) begin
          fire = 1'b1;
          hdr_bad = (bits_per_pixel_next != BPP_8 && bits_per_pixel_next != BPP_24) ||
                    width_field_next > MAX_DIM || height_field_next > MAX_DIM ||
                    data_offset_next < {16'd0, HDR_LEN} ||
                    data_offset_next > MAX_DATA_OFFSET;
          if (signature_word_next != BMP_SIGNATURE) begin
            phase_next = PH_IDLE;
            r_kind     = KIND_BAD_SIG;
          end else if (hdr_bad) begin
            phase_next = PH_IDLE;
            r_kind     = KIND_UNSUPP;
          end else begin
            r_kind = KIND_HDR_OK;
            r_w    = width_field_next[10:0];
            r_h    = height_field_next[10:0];
            if (pal_count_next == 32'd0 || pal_count_next > {23'd0, PAL_FULL}) begin
              palette_limit_next = PAL_FULL;
            end else begin
              palette_limit_next = pal_count_next[8:0];
            end
            mode8_next = (bits_per_pixel_next == BPP_8);
            if (bits_per_pixel_next == BPP_8) begin
              row_bytes_next  = 12'(({2'b00, width_field_next[10:0]} + 13'd3) & ~13'd3);
              data_limit_next = {1'b0, width_field_next[10:0]};
            end else begin
              row_bytes_next  = 12'((({2'b00, width_field_next[10:0]} +
                                      {1'b0, width_field_next[10:0], 1'b0}) + 13'd3)
                                    & ~13'd3);
              data_limit_next = 12'({2'b00, width_field_next[10:0]} +
                                    {1'b0, width_field_next[10:0], 1'b0});
            end
            if (width_field_next == 32'd0 || height_field_next == 32'd0) begin
              phase_next = PH_IDLE;
            end else if (data_offset_next == {16'd0, HDR_LEN}) begin
              phase_next = PH_PIXELS;
            end else begin
              phase_next = PH_GAP;
            end
          end
        end
      end
      PH_GAP: begin
        // palette capture: blue, green, red, reserved
        if (rel[15:PAL_IDX_W+2] == '0) begin
          we_blue  = (rel[1:0] == 2'd0);
          we_green = (rel[1:0] == 2'd1);
          we_red   = (rel[1:0] == 2'd2);
        end
        byte_position_next = pos_inc[15:0];
        if (pos_inc >= data_offset) begin
          phase_next = PH_PIXELS;
        end
      end
      PH_PIXELS: begin
        r_y = 10'(h_m1 - file_row);
        if (row_byte_count < data_limit) begin
          if (mode8) begin
            fire   = 1'b1;
            r_x    = row_byte_count[9:0];
            r_last = (file_row == h_m1) && (row_byte_count[10:0] == w_m1);
            if ({1'b0, data_byte} >= palette_limit) begin
              r_kind = KIND_SKIP;
            end else begin
              r_kind = KIND_PIXEL;
              r_pal  = 1'b1;
            end
          end else begin
            // bgr triplet assembly
            case (row_lane)
              2'd0: begin
                held_bytes_next = {8'd0, data_byte};
                row_lane_next   = 2'd1;
              end
              2'd1: begin
                held_bytes_next = {data_byte, held_bytes[7:0]};
                row_lane_next   = 2'd2;
              end
              default: begin
                fire          = 1'b1;
                r_kind        = KIND_PIXEL;
                r_x           = pix_x;
                r_r           = data_byte;
                r_g           = held_bytes[15:8];
                r_b           = held_bytes[7:0];
                r_last        = (file_row == h_m1) && ({1'b0, pix_x} == w_m1);
                row_lane_next = 2'd0;
                pix_x_next    = pix_x + 10'd1;
              end
            endcase
          end
        end
        // row end, padding consumed
        if (rc_inc >= row_bytes) begin
          row_byte_count_next = 12'd0;
          row_lane_next       = 2'd0;
          pix_x_next          = 10'd0;
          file_row_next       = row_inc;
          if (row_inc >= h11) begin
            phase_next = PH_IDLE;
          end
        end else begin
          row_byte_count_next = rc_inc;
        end
      end
      default: ;
    endcase
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= 16'd0;
      phase          <= PH_HEADER;
      signature_word <= 16'd0;
      data_offset    <= 32'd0;
      width_field    <= 32'd0;
      height_field   <= 32'd0;
      bits_per_pixel <= 16'd0;
      pal_count      <= 32'd0;
      palette_limit  <= PAL_FULL;
      file_row       <= 11'd0;
      row_byte_count <= 12'd0;
      held_bytes     <= 16'd0;
      row_bytes      <= 12'd0;
      data_limit     <= 12'd0;
      mode8          <= 1'b0;
      row_lane       <= 2'd0;
      pix_x          <= 10'd0;
    end else if (accept) begin
      byte_position  <= byte_position_next;
      phase          <= phase_next;
      signature_word <= signature_word_next;
      data_offset    <= data_offset_next;
      width_field    <= width_field_next;
      height_field   <= height_field_next;
      bits_per_pixel <= bits_per_pixel_next;
      pal_count      <= pal_count_next;
      palette_limit  <= palette_limit_next;
      file_row       <= file_row_next;
      row_byte_count <= row_byte_count_next;
      held_bytes     <= held_bytes_next;
      row_bytes      <= row_bytes_next;
      data_limit     <= data_limit_next;
      mode8          <= mode8_next;
      row_lane       <= row_lane_next;
      pix_x          <= pix_x_next;
    end
  end

  // palette memories: write during capture, registered read by byte value
  always_ff @(posedge clk) begin
    if (accept && we_red) begin
      pal_red[wr_idx] <= data_byte;
    end
    if (accept) begin
      red_q <= pal_red[data_byte[PAL_IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && we_green) begin
      pal_green[wr_idx] <= data_byte;
    end
    if (accept) begin
      green_q <= pal_green[data_byte[PAL_IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && we_blue) begin
      pal_blue[wr_idx] <= data_byte;
    end
    if (accept) begin
      blue_q <= pal_blue[data_byte[PAL_IDX_W-1:0]];
    end
  end

  // stage one valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (accept) begin
      s1_v <= fire;
    end else if (load) begin
      s1_v <= 1'b0;
    end
  end

  // stage one payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind <= r_kind;
      s1_x    <= r_x;
      s1_y    <= r_y;
      s1_r    <= r_r;
      s1_g    <= r_g;
      s1_b    <= r_b;
      s1_w    <= r_w;
      s1_h    <= r_h;
      s1_last <= r_last;
      s1_pal  <= r_pal;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // result register payload, palette colors merged here
  always_ff @(posedge clk) begin
    if (load) begin
      kind       <= s1_kind;
      x_pos      <= s1_x;
      y_pos      <= s1_y;
      red        <= s1_pal ? red_q   : s1_r;
      green      <= s1_pal ? green_q : s1_g;
      blue       <= s1_pal ? blue_q  : s1_b;
      img_width  <= s1_w;
      img_height <= s1_h;
      last_pixel <= s1_last;
    end
  end

  // checks
  `ASSERT_IMP(a_stall_full, clk, rst, byte_stall, s1_v && result_valid, "stall without full pipe")
  `ASSERT_IMP(a_dims_hdr, clk, rst, result_valid && kind != KIND_HDR_OK, img_width == 11'd0 && img_height == 11'd0, "dimensions on non-header result")
  `ASSERT_IMP(a_last_pix, clk, rst, result_valid && last_pixel, kind == KIND_PIXEL || kind == KIND_SKIP, "last mark on header result")
  `ASSERT_NXT(a_restart, clk, rst, accept && file_start, phase == PH_HEADER && byte_position == 16'd1, "file start did not restart parse")

endmodule

>>> sim/bmp_stream_pixel_decoder_top_tb.sv
// self-checking testbench for the bmp stream pixel decoder with a decode-model scoreboard
module bmp_stream_pixel_decoder_top_tb
  import bmpdec_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES    = 8;
  localparam int RANDOM_BYTES   = 200;

  // one decoder result, ordered as the result ports
  typedef struct packed {
    logic [2:0]  kind;
    logic [9:0]  x;
    logic [9:0]  y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [10:0] img_w;
    logic [10:0] img_h;
    logic        last;
  } pixel_result_t;

  // header fields used to build a stimulus file
  typedef struct {
    logic [15:0] sig;
    logic [31:0] data_offset;
    logic [31:0] width;
    logic [31:0] height;
    logic [15:0] bpp;
    logic [31:0] pal_count;
  } bmp_header_t;

  // decode model and queue of results still to come
  class pixel_scoreboard;
    logic [15:0]   byte_pos;
    logic [1:0]    phase;
    logic [15:0]   sig;
    logic [31:0]   data_offset;
    logic [31:0]   width;
    logic [31:0]   height;
    logic [15:0]   bpp;
    logic [31:0]   pal_count;
    logic [8:0]    pal_limit;
    logic [23:0]   palette [PAL_DEPTH];
    logic [10:0]   file_row;
    logic [11:0]   row_pos;
    logic [15:0]   held;
    pixel_result_t pending_q[$];
    int            errors;

    function new();
      restart();
      foreach (palette[i]) palette[i] = '0;
      errors = 0;
    endfunction

    function void restart();
      byte_pos    = '0;
      phase       = PH_HEADER;
      sig         = '0;
      data_offset = '0;
      width       = '0;
      height      = '0;
      bpp         = '0;
      pal_count   = '0;
      pal_limit   = PAL_FULL;
      file_row    = '0;
      row_pos     = '0;
      held        = '0;
    endfunction

    // advance the parser by one byte, returns 1 when a result is produced
    function bit decode_byte(logic [7:0] b, logic start, output pixel_result_t res);
      logic [15:0] p;
      logic [31:0] rel;
      logic [31:0] row_len;
      logic [31:0] rowy;
      logic [31:0] col;
      bit          has;
      res = '0;
      has = 1'b0;
      if (start) restart();
      p = byte_pos;
      case (phase)
        PH_HEADER: begin
          // little-endian header fields
          if (p < 16'd2) sig[8*p +: 8] = b;
          if (p >= 16'd10 && p < 16'd14) data_offset[8*(p-16'd10) +: 8] = b;
          if (p >= 16'd18 && p < 16'd22) width[8*(p-16'd18) +: 8] = b;
          if (p >= 16'd22 && p < 16'd26) height[8*(p-16'd22) +: 8] = b;
          if (p >= 16'd28 && p < 16'd30) bpp[8*(p-16'd28) +: 8] = b;
          if (p >= 16'd46 && p < 16'd50) pal_count[8*(p-16'd46) +: 8] = b;
          byte_pos = p + 16'd1;
          // verdict on the last header byte
          if (p == HDR_LAST) begin
            has = 1'b1;
            if (sig != BMP_SIGNATURE) begin
              phase = PH_IDLE;
              res.kind = KIND_BAD_SIG;
            end else if ((bpp != BPP_8 && bpp != BPP_24) || width > MAX_DIM ||
                         height > MAX_DIM || data_offset < {16'd0, HDR_LEN} ||
                         data_offset > MAX_DATA_OFFSET) begin
              phase = PH_IDLE;
              res.kind = KIND_UNSUPP;
            end else begin
              pal_limit = (pal_count == 0 || pal_count > PAL_DEPTH) ? PAL_FULL : pal_count[8:0];
              if (width == 0 || height == 0) phase = PH_IDLE;
              else if (data_offset == {16'd0, HDR_LEN}) phase = PH_PIXELS;
              else phase = PH_GAP;
              res.kind  = KIND_HDR_OK;
              res.img_w = width[10:0];
              res.img_h = height[10:0];
            end
          end
        end
        PH_GAP: begin
          // palette capture, reserved byte of each entry dropped
          rel = {16'd0, p} - {16'd0, HDR_LEN};
          if (rel[31:2] < PAL_DEPTH && rel[1:0] != 2'd3)
            palette[rel[9:2]][8*rel[1:0] +: 8] = b;
          byte_pos = p + 16'd1;
          if ({16'd0, byte_pos} >= data_offset) phase = PH_PIXELS;
        end
        PH_PIXELS: begin
          if (bpp == BPP_8) row_len = ((width - 1) / 4 + 1) * 4;
          else row_len = ((3 * width - 1) / 4 + 1) * 4;
          rowy  = height - 1 - {21'd0, file_row};
          res.y = rowy[9:0];
          if (bpp == BPP_8) begin
            // palette-indexed pixel
            if ({20'd0, row_pos} < width) begin
              has      = 1'b1;
              res.x    = row_pos[9:0];
              res.last = ({21'd0, file_row} == height - 1) && ({20'd0, row_pos} == width - 1);
              if ({1'b0, b} >= pal_limit) begin
                res.kind = KIND_SKIP;
              end else begin
                res.kind = KIND_PIXEL;
                {res.red, res.green, res.blue} = palette[b];
              end
            end
          end else if ({20'd0, row_pos} < 3 * width) begin
            // bgr triplet
            case (row_pos % 12'd3)
              12'd0: held = {8'd0, b};
              12'd1: held[15:8] = b;
              default: begin
                col       = {20'd0, row_pos} / 3;
                has       = 1'b1;
                res.kind  = KIND_PIXEL;
                res.x     = col[9:0];
                res.red   = b;
                res.green = held[15:8];
                res.blue  = held[7:0];
                res.last  = ({21'd0, file_row} == height - 1) && (col == width - 1);
              end
            endcase
          end
          // row padding and row advance
          row_pos = row_pos + 12'd1;
          if ({20'd0, row_pos} >= row_len) begin
            row_pos  = '0;
            file_row = file_row + 11'd1;
            if ({21'd0, file_row} >= height) phase = PH_IDLE;
          end
        end
        default: has = 1'b0;
      endcase
      return has;
    endfunction

    // accepted input transaction
    function void note_byte(logic [7:0] b, logic start);
      pixel_result_t res;
      if (decode_byte(b, start, res)) pending_q.push_back(res);
    endfunction

    function void compare_field(string name, logic [10:0] want, logic [10:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // accepted result transaction
    function void check_result(pixel_result_t got);
      pixel_result_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d", $time, got.kind);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      compare_field("kind", {8'd0, want.kind}, {8'd0, got.kind});
      compare_field("x_pos", {1'b0, want.x}, {1'b0, got.x});
      compare_field("y_pos", {1'b0, want.y}, {1'b0, got.y});
      compare_field("red", {3'd0, want.red}, {3'd0, got.red});
      compare_field("green", {3'd0, want.green}, {3'd0, got.green});
      compare_field("blue", {3'd0, want.blue}, {3'd0, got.blue});
      compare_field("img_width", want.img_w, got.img_w);
      compare_field("img_height", want.img_h, got.img_h);
      compare_field("last_pixel", {10'd0, want.last}, {10'd0, got.last});
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic [7:0]  data_byte = '0;
  logic        file_start = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [2:0]  kind;
  logic [9:0]  x_pos;
  logic [9:0]  y_pos;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [10:0] img_width;
  logic [10:0] img_height;
  logic        last_pixel;

  pixel_scoreboard sb;
  bit              quiet_phase = 1'b0;
  int              idle_cycles = 0;
  // leading palette entries fully written since reset
  int unsigned     pal_ready = 0;

  bmp_stream_pixel_decoder_top dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .data_byte    (data_byte),
    .file_start   (file_start),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .x_pos        (x_pos),
    .y_pos        (y_pos),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .img_width    (img_width),
    .img_height   (img_height),
    .last_pixel   (last_pixel)
  );

  initial begin
    forever #5ns clk = ~clk;
  end

  // idle length: mostly none or short, a few long
  function automatic int pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side stalls
  initial begin : result_stall_gen
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        result_stall <= 1'b1;
        hold--;
      end else begin
        result_stall <= 1'b0;
        if (!quiet_phase && $urandom_range(0, 2) == 0) hold = pause_len();
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0)
      sb.check_result({kind, x_pos, y_pos, red, green, blue, img_width, img_height, last_pixel});
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (byte_valid && byte_stall === 1'b0) || (result_valid === 1'b1 && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("FAIL bmp_stream_pixel_decoder_top");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(logic [7:0] b, logic start);
    int gap;
    gap = pause_len();
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    data_byte  <= b;
    file_start <= start;
    @(posedge clk);
    while (byte_stall !== 1'b0) @(posedge clk);
    sb.note_byte(b, start);
  endtask

  // hold the sender until every result is out
  task automatic wait_for_results();
    byte_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic void put_le(ref logic [7:0] q[$], input int at, input logic [31:0] v,
                                 input int n);
    for (int i = 0; i < n; i++) q[at + i] = v[8*i +: 8];
  endfunction

  // index either past the limit or on an entry already written
  function automatic logic [7:0] pick_index(int unsigned lim, int unsigned ready);
    int unsigned r;
    int unsigned top;
    r = $urandom_range(0, 9);
    top = (ready < lim) ? ready : lim;
    if (lim < 256 && (r < 3 || top == 0)) return 8'($urandom_range(lim, 255));
    if (r == 3) return 8'(top - 1);
    if (r == 4) return 8'd0;
    return 8'($urandom_range(0, top - 1));
  endfunction

  function automatic bmp_header_t make_header(logic [15:0] bpp, logic [31:0] w, logic [31:0] h,
                                               logic [31:0] offset, logic [31:0] pc);
    bmp_header_t hd;
    hd.sig         = BMP_SIGNATURE;
    hd.bpp         = bpp;
    hd.width       = w;
    hd.height      = h;
    hd.data_offset = offset;
    hd.pal_count   = pc;
    return hd;
  endfunction

  // small well-formed image with random geometry and palette settings
  function automatic bmp_header_t random_header();
    logic [31:0] w, h, off, pc;
    w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
    h = $urandom_range(1, 4);
    case ($urandom_range(0, 2))
      0: off = 54;
      1: off = 54 + 4 * $urandom_range(1, 12);
      default: off = 54 + $urandom_range(1, 50);
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2: pc = 0;
      3, 4: pc = $urandom_range(256, 32'hffff_ffff);
      default: pc = $urandom_range(1, 255);
    endcase
    return make_header($urandom_range(0, 1) ? BPP_8 : BPP_24, w, h, off, pc);
  endfunction

  // build a file and send it; counted is the number of bytes sent
  task automatic play_file(bmp_header_t hd, bit with_body, int trailing, int cut, bit with_start,
                           output int counted);
    logic [7:0]  q[$];
    int unsigned lim, row_len, n, file_ready;
    file_ready = pal_ready;
    for (int i = 0; i < 54; i++) q.push_back(8'($urandom));
    put_le(q, 0, {16'd0, hd.sig}, 2);
    put_le(q, 10, hd.data_offset, 4);
    put_le(q, 18, hd.width, 4);
    put_le(q, 22, hd.height, 4);
    put_le(q, 28, {16'd0, hd.bpp}, 2);
    put_le(q, 46, hd.pal_count, 4);
    if (with_body) begin
      for (int i = 54; i < hd.data_offset; i++) q.push_back(8'($urandom));
      // entries completed by this file's gap come before its pixels
      if (hd.data_offset > 1077) file_ready = 256;
      else if ((hd.data_offset - 53) / 4 > file_ready) file_ready = (hd.data_offset - 53) / 4;
      lim = (hd.pal_count == 0 || hd.pal_count > 256) ? 256 : hd.pal_count;
      row_len = (hd.bpp == BPP_8) ? hd.width : 3 * hd.width;
      row_len = ((row_len + 3) / 4) * 4;
      for (int y = 0; y < hd.height; y++)
        for (int i = 0; i < row_len; i++)
          q.push_back((hd.bpp == BPP_8 && i < hd.width) ? pick_index(lim, file_ready)
                                                         : 8'($urandom));
    end
    for (int i = 0; i < trailing; i++) q.push_back(8'($urandom));
    n = (cut >= 0 && cut < q.size()) ? cut : q.size();
    counted = n;
    for (int i = 0; i < n; i++) send_byte(q[i], with_start && i == 0);
    if (with_body && n == q.size() && hd.width != 0 && hd.height != 0) pal_ready = file_ready;
  endtask

  initial begin : stimulus
    bmp_header_t hd;
    int          cnt;
    int          random_bytes;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // first file right after reset, without a file start marker
    play_file(make_header(BPP_24, 2, 2, 54, 0), 1, 0, -1, 0, cnt);
    // zero count field means 256 entries, palette written ahead of the pixels
    play_file(make_header(BPP_8, 4, 2, 118, 0), 1, 0, -1, 1, cnt);
    // short palette, indices past the count are skipped
    play_file(make_header(BPP_8, 3, 2, 58, 1), 1, 0, -1, 1, cnt);
    // gap ending inside a palette entry, trailing bytes after the image
    play_file(make_header(BPP_24, 3, 2, 60, 0), 1, 7, -1, 1, cnt);
    // empty image
    play_file(make_header(BPP_24, 0, 5, 54, 0), 1, 6, -1, 1, cnt);
    // largest accepted size and offset, cut short in the gap
    play_file(make_header(BPP_8, 1024, 1024, 65535, 0), 0, 9, -1, 1, cnt);
    // bad signature checked before the bit count
    hd = make_header(BPP_8, 2, 2, 54, 0);
    hd.sig = 16'h4d43;
    hd.bpp = 16'd16;
    play_file(hd, 0, 3, -1, 1, cnt);
    // restart in the middle of the pixel data
    play_file(make_header(BPP_8, 6, 3, 54, 0), 1, 0, 64, 1, cnt);
    wait_for_results();

    // random files: mostly well formed, some cut short or corrupted
    random_bytes = 0;
    while (random_bytes < RANDOM_BYTES) begin
      quiet_phase = ($urandom_range(0, 4) == 0);
      hd = random_header();
      case ($urandom_range(0, 9))
        7: play_file(hd, 1, 0, $urandom_range(1, 120), 1, cnt);
        8, 9: begin
          case ($urandom_range(0, 3))
            0: do hd.sig = 16'($urandom); while (hd.sig == BMP_SIGNATURE);
            1: do hd.bpp = 16'($urandom); while (hd.bpp == BPP_8 || hd.bpp == BPP_24);
            2: begin
              if ($urandom_range(0, 1)) hd.width = $urandom_range(1025, 32'hffff_ffff);
              else hd.height = $urandom_range(1025, 32'hffff_ffff);
            end
            default: hd.data_offset = $urandom_range(0, 1) ? $urandom_range(0, 53)
                                                           : $urandom_range(65536, 32'hffff_ffff);
          endcase
          play_file(hd, 0, $urandom_range(0, 6), -1, 1, cnt);
        end
        default: play_file(hd, 1, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0, -1, 1,
                           cnt);
      endcase
      random_bytes += cnt;
      if ($urandom_range(0, 9) == 0) wait_for_results();
    end

    // drain and settle
    quiet_phase = 1'b0;
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS bmp_stream_pixel_decoder_top");
    end else begin
      $display("FAIL bmp_stream_pixel_decoder_top");
    end
    $finish;
  end

endmodule
